// ===== design/sscc_pkg.sv =====
// Shared constants and the arctangent table for the Stanley steering controller.
package sscc_pkg;

	// Number of CORDIC micro-rotations in each vectoring unit, 8 to 24.
	localparam int CORDIC_STEPS = 16;

	// Datapath widths: vector components and angle accumulators.
	localparam int CW = 38;
	localparam int ZW = 34;

	// CORDIC gain in Q30 and a quarter turn in 32-bit binary angle units.
	localparam logic [31:0] GAIN_Q30 = 32'd1768195363;
	localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sh0_4000_0000;

	// Arctangent of 2^-i as a 32-bit binary angle, widened to the accumulator.
	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'h20000000;
			1: v = 32'h12E4051E;
			2: v = 32'h09FB385B;
			3: v = 32'h051111D4;
			4: v = 32'h028B0D43;
			5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;
			7: v = 32'h00517C55;
			8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;
			10: v = 32'h000A2F98;
			11: v = 32'h000517CC;
			12: v = 32'h00028BE6;
			13: v = 32'h000145F3;
			14: v = 32'h0000A2FA;
			15: v = 32'h0000517D;
			16: v = 32'h000028BE;
			17: v = 32'h0000145F;
			18: v = 32'h00000A30;
			19: v = 32'h00000518;
			20: v = 32'h0000028C;
			21: v = 32'h00000146;
			22: v = 32'h000000A3;
			23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return $signed({{(ZW-32){1'b0}}, v});
	endfunction

endpackage

// ===== design/stanley_steering_controller_core.sv =====
// Stanley steering controller core: two pipelined vectoring CORDIC units and a clamp.
// Throughput: one item per cycle; the whole pipeline advances together when the
// output register is empty or its result is taken, so a stall holds every stage.
// Each CORDIC micro-rotation is one pipeline stage, which sets the latency.
// Reset clears all valid bits and loads the steering limit register max_steer_q with 4096.
module stanley_steering_controller_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] prev_target_x,
	input  logic signed [31:0] prev_target_y,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] front_x,
	input  logic signed [31:0] front_y,
	input  logic signed [15:0] yaw_angle,
	input  logic signed [15:0] speed_cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] steer_angle,
	output logic               degenerate_segment,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [14:0]        cfg_data
);

	localparam int N = sscc_pkg::CORDIC_STEPS;
	localparam int CW = sscc_pkg::CW;
	localparam int ZW = sscc_pkg::ZW;

	logic adv;
	logic [14:0] max_steer_q;

	// The pipeline moves when the output register can take a new result.
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;
	assign cfg_ready = 1'b1;

	// Steering clamp register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_steer_q <= 15'd4096;
		end else if (cfg_valid) begin
			max_steer_q <= cfg_data;
		end
	end

	// Stage 1: geometry relative to the previous target, speed offset.
	logic              v_s1, degen_s1;
	logic signed [32:0] dtx_s1, dty_s1, ux_s1, uy_s1;
	logic signed [15:0] yaw_s1;
	logic signed [16:0] spd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dtx_s1 <= 33'(target_x) - 33'(prev_target_x);
			dty_s1 <= 33'(target_y) - 33'(prev_target_y);
			ux_s1 <= 33'(front_x) - 33'(prev_target_x);
			uy_s1 <= 33'(front_y) - 33'(prev_target_y);
			degen_s1 <= (target_x == prev_target_x) && (target_y == prev_target_y);
			yaw_s1 <= yaw_angle;
			spd_s1 <= 17'(speed_cmd) + 17'sd256;
		end
	end

	// First CORDIC unit: index 0 holds the pre-rotated vectors, index k the k-th step.
	logic                v1_s   [0:N];
	logic                dg1_s  [0:N];
	logic signed [15:0]  yaw1_s [0:N];
	logic signed [48:0]  den1_s [0:N];
	logic signed [CW-1:0] c1_x_s [0:N];
	logic signed [CW-1:0] c1_y_s [0:N];
	logic signed [CW-1:0] c1_a_s [0:N];
	logic signed [CW-1:0] c1_b_s [0:N];
	logic signed [ZW-1:0] c1_z_s [0:N];

	logic signed [CW-1:0] p1x, p1y, p1a, p1b;
	logic signed [ZW-1:0] p1z;

	// Quarter-turn pre-rotation when the segment points into the left half plane.
	always_comb begin
		p1x = CW'(dtx_s1);
		p1y = CW'(dty_s1);
		p1a = CW'(ux_s1);
		p1b = CW'(uy_s1);
		p1z = '0;
		if (dtx_s1 < 0) begin
			if (dty_s1 >= 0) begin
				p1x = CW'(dty_s1);
				p1y = -CW'(dtx_s1);
				p1a = CW'(uy_s1);
				p1b = -CW'(ux_s1);
				p1z = sscc_pkg::QUARTER_TURN;
			end else begin
				p1x = -CW'(dty_s1);
				p1y = CW'(dtx_s1);
				p1a = -CW'(uy_s1);
				p1b = CW'(ux_s1);
				p1z = -sscc_pkg::QUARTER_TURN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s[0] <= 1'b0;
		end else if (adv) begin
			v1_s[0] <= v_s1;
		end
	end

	// The speed term is scaled by the CORDIC gain here, next to the pre-rotation.
	always_ff @(posedge clk) begin
		if (adv) begin
			c1_x_s[0] <= p1x;
			c1_y_s[0] <= p1y;
			c1_a_s[0] <= p1a;
			c1_b_s[0] <= p1b;
			c1_z_s[0] <= p1z;
			dg1_s[0] <= degen_s1;
			yaw1_s[0] <= yaw_s1;
			den1_s[0] <= 49'(spd_s1) * 49'($signed({1'b0, sscc_pkg::GAIN_Q30}));
		end
	end

	// Micro-rotations of the first unit; the front axle vector follows along.
	for (genvar k = 1; k <= N; k++) begin : g_c1
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v1_s[k] <= 1'b0;
			end else if (adv) begin
				v1_s[k] <= v1_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (c1_y_s[k-1] > 0) begin
					c1_x_s[k] <= c1_x_s[k-1] + (c1_y_s[k-1] >>> (k-1));
					c1_y_s[k] <= c1_y_s[k-1] - (c1_x_s[k-1] >>> (k-1));
					c1_a_s[k] <= c1_a_s[k-1] + (c1_b_s[k-1] >>> (k-1));
					c1_b_s[k] <= c1_b_s[k-1] - (c1_a_s[k-1] >>> (k-1));
					c1_z_s[k] <= c1_z_s[k-1] + sscc_pkg::atan_entry(k-1);
				end else begin
					c1_x_s[k] <= c1_x_s[k-1] - (c1_y_s[k-1] >>> (k-1));
					c1_y_s[k] <= c1_y_s[k-1] + (c1_x_s[k-1] >>> (k-1));
					c1_a_s[k] <= c1_a_s[k-1] - (c1_b_s[k-1] >>> (k-1));
					c1_b_s[k] <= c1_b_s[k-1] + (c1_a_s[k-1] >>> (k-1));
					c1_z_s[k] <= c1_z_s[k-1] - sscc_pkg::atan_entry(k-1);
				end
				dg1_s[k] <= dg1_s[k-1];
				yaw1_s[k] <= yaw1_s[k-1];
				den1_s[k] <= den1_s[k-1];
			end
		end
	end

	// Stage 3: heading error wrapped to one turn, cross-track numerator and denominator.
	logic               v_s3, dg_s3, zero_s3;
	logic signed [31:0] herr_s3;
	logic signed [CW-1:0] num_s3, den_s3;
	logic signed [CW-1:0] num_c, den_c;

	assign num_c = -c1_b_s[N];
	assign den_c = CW'(den1_s[N] >>> 28);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v1_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			herr_s3 <= $signed(c1_z_s[N][31:0] - {yaw1_s[N], 16'h0000});
			num_s3 <= num_c;
			den_s3 <= den_c;
			zero_s3 <= (num_c == '0) && (den_c == '0);
			dg_s3 <= dg1_s[N];
		end
	end

	// Second CORDIC unit: atan2 of the cross-track error against the speed term.
	logic                v2_s    [0:N];
	logic                dg2_s   [0:N];
	logic                zr2_s   [0:N];
	logic signed [31:0]  herr2_s [0:N];
	logic signed [CW-1:0] c2_x_s [0:N];
	logic signed [CW-1:0] c2_y_s [0:N];
	logic signed [ZW-1:0] c2_z_s [0:N];

	logic signed [CW-1:0] p2x, p2y;
	logic signed [ZW-1:0] p2z;

	// Quarter-turn pre-rotation for a negative denominator.
	always_comb begin
		p2x = den_s3;
		p2y = num_s3;
		p2z = '0;
		if (den_s3 < 0) begin
			if (num_s3 >= 0) begin
				p2x = num_s3;
				p2y = -den_s3;
				p2z = sscc_pkg::QUARTER_TURN;
			end else begin
				p2x = -num_s3;
				p2y = den_s3;
				p2z = -sscc_pkg::QUARTER_TURN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s[0] <= 1'b0;
		end else if (adv) begin
			v2_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c2_x_s[0] <= p2x;
			c2_y_s[0] <= p2y;
			c2_z_s[0] <= p2z;
			dg2_s[0] <= dg_s3;
			zr2_s[0] <= zero_s3;
			herr2_s[0] <= herr_s3;
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_c2
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v2_s[k] <= 1'b0;
			end else if (adv) begin
				v2_s[k] <= v2_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (c2_y_s[k-1] > 0) begin
					c2_x_s[k] <= c2_x_s[k-1] + (c2_y_s[k-1] >>> (k-1));
					c2_y_s[k] <= c2_y_s[k-1] - (c2_x_s[k-1] >>> (k-1));
					c2_z_s[k] <= c2_z_s[k-1] + sscc_pkg::atan_entry(k-1);
				end else begin
					c2_x_s[k] <= c2_x_s[k-1] - (c2_y_s[k-1] >>> (k-1));
					c2_y_s[k] <= c2_y_s[k-1] + (c2_x_s[k-1] >>> (k-1));
					c2_z_s[k] <= c2_z_s[k-1] - sscc_pkg::atan_entry(k-1);
				end
				dg2_s[k] <= dg2_s[k-1];
				zr2_s[k] <= zr2_s[k-1];
				herr2_s[k] <= herr2_s[k-1];
			end
		end
	end

	// Final stage: add both terms, clamp to the limit, round to 16-bit angle units; zero if degenerate.
	logic signed [ZW-1:0] cta;
	logic signed [34:0]   sum, lim, clamped, rnd;
	logic                 out_valid_q, degen_q;
	logic signed [15:0]   steer_q;

	always_comb begin
		cta = zr2_s[N] ? '0 : c2_z_s[N];
		sum = 35'(herr2_s[N]) + 35'(cta);
		lim = $signed({4'b0000, max_steer_q, 16'h0000});
		clamped = sum;
		if (sum > lim) begin
			clamped = lim;
		end
		if (sum < -lim) begin
			clamped = -lim;
		end
		rnd = (clamped + 35'sd32768) >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v2_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			steer_q <= dg2_s[N] ? 16'sd0 : rnd[15:0];
			degen_q <= dg2_s[N];
		end
	end

	assign out_valid = out_valid_q;
	assign steer_angle = steer_q;
	assign degenerate_segment = degen_q;

	// A coincident segment always gives zero steering.
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate_segment |-> steer_angle == 16'sd0)
		else $error("degenerate segment with nonzero steering");

	// An input transfer shows up as a valid first stage.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted item missing from first stage");

	// While stalled, the valid bits in the middle of the pipeline hold.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v1_s[N]) && $stable(v_s3) && $stable(v2_s[N]))
		else $error("pipeline moved during a stall");

endmodule

// ===== test/tb_stanley_steering_controller_core.sv =====
// Self-checking testbench for the Stanley steering controller core.
`timescale 1ns / 1ps

module tb_stanley_steering_controller_core;

	localparam int RUN_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 2 * sscc_pkg::CORDIC_STEPS + 12;
	localparam int STALL_CYCLES = 300;
	localparam int RANDOM_PER_PHASE = 440;

	// Arctangent of 2^-i in 32-bit binary angle units.
	localparam longint ATAN_LUT [24] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
		64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};
	localparam longint QTURN = 64'sd1073741824;
	localparam longint KGAIN = 64'sd1768195363;

	typedef struct {
		logic signed [31:0] px, py, tx, ty, fx, fy;
		logic signed [15:0] yaw, spd;
	} pose_t;

	typedef struct {
		logic signed [15:0] steer;
		logic               degen;
	} steer_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic signed [31:0] prev_target_x, prev_target_y, target_x, target_y, front_x, front_y;
	logic signed [15:0] yaw_angle, speed_cmd, steer_angle;
	logic degenerate_segment;
	logic [14:0] cfg_data;

	steer_t steer_q[$];
	logic [14:0] steer_limit;
	int sent_cnt, checked_cnt, degen_cnt, clamp_cnt, err_cnt, cycle_cnt;
	int tx_idle_pct, rx_idle_pct;
	bit rx_hold;

	stanley_steering_controller_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.prev_target_x(prev_target_x), .prev_target_y(prev_target_y),
		.target_x(target_x), .target_y(target_y),
		.front_x(front_x), .front_y(front_y),
		.yaw_angle(yaw_angle), .speed_cmd(speed_cmd),
		.out_valid(out_valid), .out_ready(out_ready),
		.steer_angle(steer_angle), .degenerate_segment(degenerate_segment),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Vectoring CORDIC: angle of (x, y), with the same rotations applied to (a, b).
	function automatic longint vector_angle(input longint x0, input longint y0,
			inout longint a, inout longint b);
		longint x, y, z, t, xs, ys, ua, ub;
		x = x0;
		y = y0;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t;
				t = a; a = b; b = -t;
				z = QTURN;
			end else begin
				t = x; x = -y; y = t;
				t = a; a = -b; b = t;
				z = -QTURN;
			end
		end
		for (int i = 0; i < sscc_pkg::CORDIC_STEPS && i < 24; i++) begin
			xs = x >>> i; ys = y >>> i; ua = a >>> i; ub = b >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; a = a + ub; b = b - ua;
				z += ATAN_LUT[i];
			end else begin
				x = x - ys; y = y + xs; a = a - ub; b = b + ua;
				z -= ATAN_LUT[i];
			end
		end
		return z;
	endfunction

	// Expected steering command for one pose under the current limit.
	function automatic steer_t stanley_steer(input pose_t p);
		steer_t r;
		longint dtx, dty, ux, uy, dir, den, cta, sum, lim, zx, zy;
		logic [31:0] diff;
		dtx = longint'(p.tx) - longint'(p.px);
		dty = longint'(p.ty) - longint'(p.py);
		ux = longint'(p.fx) - longint'(p.px);
		uy = longint'(p.fy) - longint'(p.py);
		zx = 0;
		zy = 0;
		r.steer = '0;
		r.degen = 1'b1;
		if (dtx == 0 && dty == 0)
			return r;
		dir = vector_angle(dtx, dty, ux, uy);
		diff = dir[31:0] - {p.yaw, 16'h0000};
		den = ((256 + longint'(p.spd)) * KGAIN) >>> 28;
		cta = vector_angle(den, -uy, zx, zy);
		sum = longint'($signed(diff)) + cta;
		lim = longint'(steer_limit) * 65536;
		if (sum > lim)
			sum = lim;
		if (sum < -lim)
			sum = -lim;
		sum = (sum + 32768) >>> 16;
		r.steer = sum[15:0];
		r.degen = 1'b0;
		return r;
	endfunction

	// Present one pose and hold it until its transfer.
	task automatic send_pose(input pose_t p);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		prev_target_x <= p.px; prev_target_y <= p.py;
		target_x <= p.tx; target_y <= p.ty;
		front_x <= p.fx; front_y <= p.fy;
		yaw_angle <= p.yaw; speed_cmd <= p.spd;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		steer_q.push_back(stanley_steer(p));
		sent_cnt++;
	endtask

	// Sender rests until every expected result is back and the pipeline is empty.
	task automatic drain();
		in_valid <= 1'b0;
		wait (steer_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [14:0] v);
		drain();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		steer_limit = v;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [31:0] near(input logic signed [31:0] base);
		return base + $signed(32'($urandom_range(2 * 65536)) - 32'd65536);
	endfunction

	// Mostly local geometry around a random origin; some full-range and degenerate poses.
	function automatic pose_t random_pose();
		pose_t p;
		int kind;
		kind = $urandom_range(99);
		p.px = $urandom; p.py = $urandom;
		p.tx = near(p.px); p.ty = near(p.py);
		p.fx = near(p.px); p.fy = near(p.py);
		p.yaw = 16'($urandom); p.spd = $signed(16'($urandom_range(2560))) - 16'sd256;
		if (kind < 15) begin
			p.tx = $urandom; p.ty = $urandom; p.fx = $urandom; p.fy = $urandom;
			p.spd = 16'($urandom);
		end else if (kind < 22) begin
			p.tx = p.px; p.ty = p.py;
		end else if (kind < 27) begin
			p.spd = -16'sd256;
		end
		return p;
	endfunction

	// Result checker: each transfer against the oldest expectation.
	always @(posedge clk) begin
		steer_t e;
		if (arst_n && out_valid && out_ready) begin
			if (steer_q.size() == 0) begin
				$error("result with nothing expected: steer_angle=%0d", steer_angle);
				err_cnt++;
			end else begin
				e = steer_q.pop_front();
				checked_cnt++;
				if (e.degen)
					degen_cnt++;
				if (e.steer == $signed({1'b0, steer_limit}) ||
						e.steer == -$signed({1'b0, steer_limit}))
					clamp_cnt++;
				if (steer_angle !== e.steer) begin
					$error("steer_angle: expected %0d, got %0d", e.steer, steer_angle);
					err_cnt++;
				end
				if (degenerate_segment !== e.degen) begin
					$error("degenerate_segment: expected %0b, got %0b",
						e.degen, degenerate_segment);
					err_cnt++;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				out_ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
			end
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog on the run length.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > RUN_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic test_directed();
		pose_t p;
		// Segment along +x from the origin with the front on the line.
		p = '{default: '0};
		p.tx = 32'sd10240;
		send_pose(p);
		p.yaw = -16'sd32768;
		send_pose(p);
		p.yaw = 16'sd32767;
		send_pose(p);
		// Coincident targets.
		p.tx = 32'sd0;
		send_pose(p);
		p.px = 32'h7FFFFFFF; p.py = 32'h80000000; p.tx = p.px; p.ty = p.py;
		send_pose(p);
		// Speed of -1 m/s, with and without cross-track offset.
		p = '{default: '0};
		p.tx = 32'sd4096; p.ty = 32'sd4096; p.spd = -16'sd256;
		send_pose(p);
		p.fy = 32'sd2048;
		send_pose(p);
		// Negative denominator on the line, and extreme speeds.
		p.fy = 32'sd0; p.spd = -16'sd32768;
		send_pose(p);
		p.fy = -32'sd5000;
		send_pose(p);
		p.spd = 16'sd32767;
		send_pose(p);
		// Segment pointing backward: heading error near half a turn.
		p = '{default: '0};
		p.tx = -32'sd8192;
		send_pose(p);
		p.ty = -32'sd1;
		send_pose(p);
		// Extremes of the coordinate range.
		p.px = 32'h80000000; p.py = 32'h80000000;
		p.tx = 32'h7FFFFFFF; p.ty = 32'h7FFFFFFF;
		p.fx = 32'h7FFFFFFF; p.fy = 32'h80000000;
		p.yaw = 16'h7FFF; p.spd = 16'h7FFF;
		send_pose(p);
		p.px = 32'h7FFFFFFF; p.py = 32'h7FFFFFFF;
		p.tx = 32'h80000000; p.ty = 32'h80000000;
		p.fx = 32'h80000000; p.fy = 32'h7FFFFFFF;
		p.yaw = 16'h8000; p.spd = 16'h8000;
		send_pose(p);
		p.tx = 32'hFFFFFFFF; p.ty = 32'h00000000; p.fx = 32'hFFFFFFFF; p.fy = 32'hFFFFFFFF;
		p.yaw = 16'hFFFF; p.spd = 16'hFFFF;
		send_pose(p);
		drain();
	endtask

	// Steering limit swept through its range, including zero and the register maximum.
	task automatic test_limits();
		logic [14:0] limits [5] = '{15'd0, 15'd16384, 15'h7FFF, 15'd1, 15'd4096};
		foreach (limits[i]) begin
			write_limit(limits[i]);
			repeat (12) send_pose(random_pose());
		end
		drain();
	endtask

	task automatic test_random(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		write_limit(15'($urandom_range(16384, 512)));
		repeat (RANDOM_PER_PHASE) send_pose(random_pose());
		drain();
	endtask

	// Receiver holds off long enough for the pipeline to fill and stall the input.
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold = 1'b1;
		repeat (80) send_pose(random_pose());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		{prev_target_x, prev_target_y, target_x, target_y, front_x, front_y} = '0;
		yaw_angle = '0;
		speed_cmd = '0;
		steer_limit = 15'd4096;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_limits();
		test_random(6, 48);
		test_random(48, 6);
		test_random(0, 0);
		test_backpressure();
		drain();

		$display("Checked %0d steering results from %0d poses.", checked_cnt, sent_cnt);
		$display("Degenerate segments: %0d, clamped commands: %0d.", degen_cnt, clamp_cnt);
		if (err_cnt == 0 && steer_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/sscc_pkg.sv
design/stanley_steering_controller_core.sv
test/tb_stanley_steering_controller_core.sv
